/* rtl/core/cfd_pkg.sv */
// Shared types and constants for the complex FIR decimator.
package cfd_pkg;

    localparam int DATA_W      = 16;
    localparam int COEF_IDX_W  = 7;
    localparam int FACTOR_W    = 7;
    localparam int PHASE_W     = 6;
    localparam int FACTOR_MAX  = 64;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 7'd8;
    localparam logic [PADDR_W-1:0]  ADDR_FACTOR  = 3'h0;

    localparam logic MODE_COEF   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sample;
        logic load_coef;
        logic mac_start;
        logic mac_issue;
        logic round_load;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;
        logic issue_last;
        logic pipe_busy;
        logic out_busy;
    } sts_t;

endpackage

/* rtl/core/cfd_in_if.sv */
// Input channel: one coefficient or complex sample per transfer.
interface cfd_in_if import cfd_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [COEF_IDX_W-1:0]        coef_index;
    logic signed [DATA_W-1:0]     coef_value;
    logic signed [DATA_W-1:0]     sample_i;
    logic signed [DATA_W-1:0]     sample_q;

    modport source (
        output valid, mode, coef_index, coef_value, sample_i, sample_q,
        input  ready
    );
    modport sink (
        input  valid, mode, coef_index, coef_value, sample_i, sample_q,
        output ready
    );
endinterface

/* rtl/core/cfd_out_if.sv */
// Output channel: one filtered complex sample per transfer.
interface cfd_out_if import cfd_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_i;
    logic signed [DATA_W-1:0] out_q;

    modport source (
        output valid, out_i, out_q,
        input  ready
    );
    modport sink (
        input  valid, out_i, out_q,
        output ready
    );
endinterface

/* rtl/core/cfd_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module cfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/cfd_datapath.sv */
// Datapath: history and tap stores, phase tracking, MAC pipeline, rounding, output register.
module cfd_datapath import cfd_pkg::*; #(
    parameter int NUM_TAPS = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic [FACTOR_W-1:0]       factor,
    input  logic [COEF_IDX_W-1:0]     coef_index,
    input  logic signed [DATA_W-1:0]  coef_value,
    input  logic signed [DATA_W-1:0]  sample_i,
    input  logic signed [DATA_W-1:0]  sample_q,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [DATA_W-1:0]  out_i,
    output logic signed [DATA_W-1:0]  out_q
);

    localparam int AW    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W = PROD_W + AW;
    localparam logic [AW-1:0] LAST = AW'(NUM_TAPS - 1);

    logic [AW-1:0]             wptr_reg, wptr_next;
    logic                      wrapped_reg;
    logic [PHASE_W-1:0]        phase_reg;
    logic [PHASE_W:0]          phase_inc;
    logic [FACTOR_W-1:0]       eff_factor;
    logic                      coef_in_range;

    logic [AW-1:0]             idx_reg, tap_reg;
    logic                      hist_hit;
    logic                      rd_valid_reg, hit_reg, prod_valid_reg;
    logic [2*DATA_W-1:0]       hist_rdata;
    logic [DATA_W-1:0]         coef_rdata;
    logic signed [PROD_W-1:0]  prod_i_reg, prod_q_reg;
    logic signed [ACC_W-1:0]   acc_i_reg, acc_q_reg;
    logic signed [ACC_W:0]     rnd_i, rnd_q;
    logic signed [DATA_W-1:0]  res_i_reg, res_q_reg;
    logic signed [DATA_W-1:0]  out_i_reg, out_q_reg;
    logic                      out_valid_reg;

    // Round-half-up already added; drop 15 fraction bits and clamp to 16 bits.
    function automatic logic [DATA_W-1:0] sat16(input logic signed [ACC_W:0] v);
        logic fits;
        fits = (v[ACC_W:2*DATA_W-2] == '0) || (v[ACC_W:2*DATA_W-2] == '1);
        if (fits)
            return v[2*DATA_W-2:DATA_W-1];
        else if (v[ACC_W])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    always_comb
    begin
        eff_factor = factor;
        if (factor == '0)
            eff_factor = FACTOR_W'(1);
        else if (factor > FACTOR_W'(FACTOR_MAX))
            eff_factor = FACTOR_W'(FACTOR_MAX);
    end

    assign phase_inc     = {1'b0, phase_reg} + (PHASE_W+1)'(1);
    assign wptr_next     = (wptr_reg == LAST) ? '0 : wptr_reg + AW'(1);
    assign coef_in_range = 32'(coef_index) < NUM_TAPS;
    assign hist_hit      = wrapped_reg || (idx_reg < wptr_reg);

    assign sts.emit       = phase_inc >= eff_factor;
    assign sts.issue_last = tap_reg == LAST;
    assign sts.pipe_busy  = rd_valid_reg || prod_valid_reg;
    assign sts.out_busy   = out_valid_reg && !out_ready;

    cfd_ram #(.WIDTH(2*DATA_W), .DEPTH(NUM_TAPS)) u_hist_ram (
        .clk   (clk),
        .we    (cmd.load_sample),
        .waddr (wptr_reg),
        .wdata ({sample_i, sample_q}),
        .raddr (idx_reg),
        .rdata (hist_rdata)
    );

    cfd_ram #(.WIDTH(DATA_W), .DEPTH(NUM_TAPS)) u_coef_ram (
        .clk   (clk),
        .we    (cmd.load_coef && coef_in_range),
        .waddr (AW'(coef_index)),
        .wdata (coef_value),
        .raddr (tap_reg),
        .rdata (coef_rdata)
    );

    // Write pointer, wrap flag (stands in for zero-clearing the history) and phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg    <= '0;
            wrapped_reg <= 1'b0;
            phase_reg   <= '0;
        end
        else if (cmd.load_sample)
        begin
            wptr_reg <= wptr_next;
            if (wptr_reg == LAST)
            begin
                wrapped_reg <= 1'b1;
            end
            phase_reg <= sts.emit ? '0 : phase_inc[PHASE_W-1:0];
        end
    end

    // Read sequencer: walk taps up and history down from the newest entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            tap_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.mac_start)
            begin
                idx_reg <= wptr_reg;
                tap_reg <= '0;
            end
            else if (cmd.mac_issue)
            begin
                idx_reg <= (idx_reg == '0) ? LAST : idx_reg - AW'(1);
                tap_reg <= tap_reg + AW'(1);
            end
            rd_valid_reg   <= cmd.mac_issue;
            hit_reg        <= hist_hit;
            prod_valid_reg <= rd_valid_reg;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_reg)
        begin
            prod_i_reg <= $signed(coef_rdata) * $signed(hist_rdata[2*DATA_W-1:DATA_W]);
            prod_q_reg <= $signed(coef_rdata) * $signed(hist_rdata[DATA_W-1:0]);
        end
        else
        begin
            prod_i_reg <= '0;
            prod_q_reg <= '0;
        end

        if (cmd.mac_start)
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_i_reg <= acc_i_reg + {{(ACC_W-PROD_W){prod_i_reg[PROD_W-1]}}, prod_i_reg};
            acc_q_reg <= acc_q_reg + {{(ACC_W-PROD_W){prod_q_reg[PROD_W-1]}}, prod_q_reg};
        end

        if (cmd.round_load)
        begin
            res_i_reg <= sat16(rnd_i);
            res_q_reg <= sat16(rnd_q);
        end

        if (cmd.out_load)
        begin
            out_i_reg <= res_i_reg;
            out_q_reg <= res_q_reg;
        end
    end

    assign rnd_i = {acc_i_reg[ACC_W-1], acc_i_reg} + (ACC_W+1)'(1 << (DATA_W - 2));
    assign rnd_q = {acc_q_reg[ACC_W-1], acc_q_reg} + (ACC_W+1)'(1 << (DATA_W - 2));

    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;

endmodule

/* rtl/core/cfd_ctrl.sv */
// Controller: sequences intake, MAC pass, pipeline drain, rounding and result hand-off.
module cfd_ctrl import cfd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_mode,
    input  sts_t sts,
    output logic in_ready,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_mode == MODE_SAMPLE && sts.emit)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (sts.issue_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_sample = in_mode == MODE_SAMPLE;
                    cmd.load_coef   = in_mode == MODE_COEF;
                    cmd.mac_start   = in_mode == MODE_SAMPLE && sts.emit;
                end
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round_load = 1'b1;
            end
            ST_OUT:
            begin
                cmd.out_load = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/complex_fir_decimator.sv */
// Complex FIR decimator top level: APB register, controller and datapath.
//
// Each input transfer either loads one real Q1.15 tap (mode 0) or pushes one
// complex Q1.15 sample (mode 1) into a circular history of NUM_TAPS entries.
// Every decimation_factor-th sample (factor 0 acts as 1, above 64 as 64)
// starts one filter pass: a single complex MAC (two 16x16 multipliers) walks
// all NUM_TAPS taps, one tap per cycle, reading the tap store and the history
// store from one read port each. A tap load, or a sample that does not
// complete a decimation period, leaves intake open. A sample that completes a
// period holds intake closed while its pass runs: the NUM_TAPS tap issues,
// the drain of the two-stage MAC pipeline, rounding, and the hand-off to the
// output register. The result sits in an output register, so intake carries
// on while a finished result waits to be taken; the hand-off of a second
// result, and intake with it, waits until the first is taken. History reads
// as zero until written, with no clearing pass after reset; taps must be
// written before the first pass.
// Outputs are the sum divided by 2^15, rounded half up and saturated to
// 16 bits. Write decimation_factor at byte address 0 only while the block is
// idle.
module complex_fir_decimator import cfd_pkg::*; #(
    parameter int NUM_TAPS = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    cfd_in_if.sink              din,
    cfd_out_if.source           dout,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [FACTOR_W-1:0] factor_reg;
    logic                cfg_write;
    cmd_t                cmd;
    sts_t                sts;

    // Configuration register: write on the APB access phase, no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            factor_reg <= FACTOR_RESET;
        else if (cfg_write && paddr == ADDR_FACTOR)
            factor_reg <= pwdata[FACTOR_W-1:0];
    end

    assign prdata = (paddr == ADDR_FACTOR) ? PDATA_W'(factor_reg) : '0;

    // Controller: owns the input handshake and sequences the filter pass.
    cfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_mode  (din.mode),
        .sts      (sts),
        .in_ready (din.ready),
        .cmd      (cmd)
    );

    // Datapath: stores, MAC pipeline and output register.
    cfd_datapath #(.NUM_TAPS(NUM_TAPS)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .factor     (factor_reg),
        .coef_index (din.coef_index),
        .coef_value (din.coef_value),
        .sample_i   (din.sample_i),
        .sample_q   (din.sample_q),
        .out_ready  (dout.ready),
        .out_valid  (dout.valid),
        .out_i      (dout.out_i),
        .out_q      (dout.out_q)
    );

    // A tap load never starts a filter pass: intake stays open.
    a_coef_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready && din.mode == MODE_COEF |=> din.ready)
        else $error("tap load left the idle state");

    // Rounding only sees a fully drained accumulator.
    a_round_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_load |-> !sts.pipe_busy)
        else $error("rounding before MAC pipeline drained");

    // A new result never overwrites one still waiting to be taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(dout.valid && !dout.ready))
        else $error("pending result overwritten");

    // A filter pass starts only together with a sample write.
    a_start_with_sample: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_start |-> cmd.load_sample && sts.emit)
        else $error("filter pass started without a sample");

endmodule

/* test/testbench.sv */
// Self-checking testbench for complex_fir_decimator: directed table, then random transfers.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cfd_pkg::*;

    localparam int NUM_TAPS    = 128;
    // Margin past one full filter pass, waited out before a register write.
    localparam int SETTLE      = NUM_TAPS + 16;
    localparam int LIMIT       = 2_000_000;
    localparam int NO_CFG      = -1;
    localparam int PHASE_ITEMS = 190;
    localparam int N_PHASES    = 10;
    localparam int FACTOR_TOP  = (1 << FACTOR_W) - 1;
    localparam int COEF_PCT    = 8;

    // One input transfer as the block sees it.
    typedef struct packed {
        logic                     mode;
        logic [COEF_IDX_W-1:0]    coef_index;
        logic signed [DATA_W-1:0] coef_value;
        logic signed [DATA_W-1:0] sample_i;
        logic signed [DATA_W-1:0] sample_q;
    } xfer_t;

    // One filtered complex output.
    typedef struct packed {
        logic signed [DATA_W-1:0] out_i;
        logic signed [DATA_W-1:0] out_q;
    } iq_t;

    // Directed row: optional factor write first, then one transfer, then an optional
    // hand-typed expectation (otherwise the filter model decides).
    typedef struct packed {
        int   factor;
        logic mode;
        int   idx;
        int   cval;
        int   si;
        int   sq;
        bit   typed;
        int   ei;
        int   eq;
    } dir_row_t;

    // The preload leaves tap 0 at -1.0 and every other tap at zero, so with a factor of 1
    // the first rows simply negate the newest sample.
    localparam int N_DIR = 17;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // negation of full scale; -(-32768) saturates to 32767
        '{1,          MODE_SAMPLE, 0,   0,      32767,  -32768, 1'b1, -32767, 32767},
        '{NO_CFG,     MODE_SAMPLE, 0,   0,      0,      1,      1'b1, 0,      -1},
        '{NO_CFG,     MODE_SAMPLE, 0,   0,      -1,     0,      1'b1, 1,      0},
        // tap loads carry junk in the sample fields, which must be ignored
        '{NO_CFG,     MODE_COEF,   0,   32767,  -1,     -32768, 1'b0, 0,      0},
        '{NO_CFG,     MODE_COEF,   1,   32767,  32767,  -1,     1'b0, 0,      0},
        '{NO_CFG,     MODE_SAMPLE, 0,   0,      32767,  -32768, 1'b0, 0,      0},
        // two full-scale products push the sum past both rails
        '{NO_CFG,     MODE_SAMPLE, 0,   0,      32767,  -32768, 1'b1, 32767,  -32768},
        '{NO_CFG,     MODE_COEF,   127, -32768, 0,      0,      1'b0, 0,      0},
        '{NO_CFG,     MODE_COEF,   64,  1,      0,      0,      1'b0, 0,      0},
        // factor zero behaves as one
        '{0,          MODE_SAMPLE, 0,   0,      1234,   -4321,  1'b0, 0,      0},
        '{NO_CFG,     MODE_SAMPLE, 0,   0,      -32768, 32767,  1'b0, 0,      0},
        // build up a partial count at the largest factor ...
        '{FACTOR_MAX, MODE_SAMPLE, 0,   0,      100,    -100,   1'b0, 0,      0},
        '{NO_CFG,     MODE_SAMPLE, 0,   0,      200,    -200,   1'b0, 0,      0},
        '{NO_CFG,     MODE_SAMPLE, 0,   0,      300,    -300,   1'b0, 0,      0},
        // ... then lower the factor below it: the next sample must emit at once
        '{2,          MODE_SAMPLE, 0,   0,      400,    -400,   1'b0, 0,      0},
        '{NO_CFG,     MODE_SAMPLE, 0,   0,      500,    -500,   1'b0, 0,      0},
        '{NO_CFG,     MODE_SAMPLE, 0,   0,      600,    -600,   1'b0, 0,      0}
    };

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cfd_in_if  in_ch ();
    cfd_out_if out_ch ();

    complex_fir_decimator #(
        .NUM_TAPS (NUM_TAPS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (in_ch),
        .dout    (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Filter model state: its own copy of history, taps, pointer, phase and factor.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] hist_i    [NUM_TAPS];
    logic signed [DATA_W-1:0] hist_q    [NUM_TAPS];
    logic signed [DATA_W-1:0] tap_store [NUM_TAPS];
    int                       wr_ptr;
    int                       phase_cnt;
    logic [FACTOR_W-1:0]      factor_reg;

    // Filtered outputs still owed by the block, oldest first.
    iq_t expected_filtered [$];

    int errors;
    int n_taps;
    int n_samples;
    int n_checked;
    int n_sat;
    int n_cfg;
    int cycles;

    task automatic report(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Append one owed output at the tail of the queue.
    function automatic void owe_result(input iq_t v);
        expected_filtered = {expected_filtered, v};
    endfunction

    // Divide by 2^15 rounding half up (floor after adding half), then clamp to 16 bits.
    function automatic logic signed [DATA_W-1:0] round_sat(input longint acc);
        longint q;
        q = (acc + 64'sd16384) >>> 15;
        if (q > 32767)
        begin
            q = 32767;
            n_sat++;
        end
        else if (q < -32768)
        begin
            q = -32768;
            n_sat++;
        end
        return q[DATA_W-1:0];
    endfunction

    // Advance the model by one accepted transfer; hit tells whether it owes an output.
    function automatic void decimate_step(input xfer_t x, output logic hit, output iq_t res);
        longint acc_i;
        longint acc_q;
        int     idx;
        int     eff;
        hit = 1'b0;
        res = '0;
        if (x.mode == MODE_COEF)
        begin
            // Out-of-range indexes drop; with 128 taps a 7-bit index cannot reach that.
            if (int'(x.coef_index) < NUM_TAPS)
                tap_store[x.coef_index] = x.coef_value;
            return;
        end
        hist_i[wr_ptr] = x.sample_i;
        hist_q[wr_ptr] = x.sample_q;
        wr_ptr = (wr_ptr + 1) % NUM_TAPS;
        // Factor zero acts as one, anything past the maximum acts as the maximum.
        eff = int'(factor_reg);
        if (eff == 0)
            eff = 1;
        else if (eff > FACTOR_MAX)
            eff = FACTOR_MAX;
        phase_cnt++;
        // At-or-above compare: a factor lowered mid-count fires on the next sample.
        if (phase_cnt < eff)
            return;
        phase_cnt = 0;
        acc_i = 0;
        acc_q = 0;
        idx = wr_ptr;
        // Tap k pairs with the sample k places back from the newest one.
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            idx = (idx + NUM_TAPS - 1) % NUM_TAPS;
            acc_i += longint'(tap_store[k]) * longint'(hist_i[idx]);
            acc_q += longint'(tap_store[k]) * longint'(hist_q[idx]);
        end
        res.out_i = round_sat(acc_i);
        res.out_q = round_sat(acc_q);
        hit = 1'b1;
    endfunction

    // Random 16-bit word weighted toward the rails and toward small values.
    function automatic logic signed [DATA_W-1:0] rand_word();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        v = int'($urandom_range(0, 64)) - 32;
        case (pick)
            0:       return DATA_W'(32767);
            1:       return DATA_W'(-32768);
            2, 3:    return DATA_W'(v);
            default: return DATA_W'($urandom());
        endcase
    endfunction

    function automatic xfer_t random_xfer(input int coef_pct);
        xfer_t x;
        x.mode       = ($urandom_range(0, 99) < coef_pct) ? MODE_COEF : MODE_SAMPLE;
        x.coef_index = COEF_IDX_W'($urandom_range(0, NUM_TAPS - 1));
        x.coef_value = rand_word();
        x.sample_i   = rand_word();
        x.sample_q   = rand_word();
        return x;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            report("cycle limit reached with work outstanding");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Output side: stall on its own pattern of short runs, long stalls and
    // occasional long stretches of steady ready.
    // ------------------------------------------------------------------
    initial
    begin
        int kind;
        int span;
        forever
        begin
            kind = $urandom_range(0, 19);
            if (kind < 10)
            begin
                out_ch.ready <= 1'b1;
                span = $urandom_range(1, 24);
            end
            else if (kind < 19)
            begin
                out_ch.ready <= 1'b0;
                span = $urandom_range(1, 48);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                span = $urandom_range(200, 400);
            end
            repeat (span) @(posedge clk);
        end
    end

    // Score every output transfer against the oldest owed result.
    always @(posedge clk)
    begin
        iq_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_filtered.size() == 0)
            begin
                report($sformatf("output with nothing owed: i=%0d q=%0d",
                                 out_ch.out_i, out_ch.out_q));
            end
            else
            begin
                want = expected_filtered.pop_front();
                n_checked++;
                if (out_ch.out_i !== want.out_i)
                    report($sformatf("out_i got %0d, want %0d", out_ch.out_i, want.out_i));
                if (out_ch.out_q !== want.out_q)
                    report($sformatf("out_q got %0d, want %0d", out_ch.out_q, want.out_q));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side and register port
    // ------------------------------------------------------------------

    // One APB transfer to the factor register: setup, access, then an idle wait with psel low so a
    // following access never raises psel in the step that lowers it.
    task automatic apb_xfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_FACTOR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write the factor, mirror it in the model, read it back.
    task automatic set_factor(input int f);
        logic [PDATA_W-1:0] rd;
        apb_xfer(1'b1, PDATA_W'(f), rd);
        factor_reg = FACTOR_W'(f);
        n_cfg++;
        apb_xfer(1'b0, '0, rd);
        if (rd !== PDATA_W'(factor_reg))
            report($sformatf("factor readback %0d, want %0d", rd, factor_reg));
    endtask

    // Offer one transfer and hold it until taken, then advance the model.
    task automatic send(input xfer_t x, output logic hit, output iq_t res);
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= x.mode;
        in_ch.coef_index <= x.coef_index;
        in_ch.coef_value <= x.coef_value;
        in_ch.sample_i   <= x.sample_i;
        in_ch.sample_q   <= x.sample_q;
        do @(posedge clk); while (!in_ch.ready);
        decimate_step(x, hit, res);
        if (x.mode == MODE_COEF)
            n_taps++;
        else
            n_samples++;
    endtask

    // Drop valid, wait for every owed output, then let a full pass worth of cycles go by
    // so that nothing is still in flight.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_filtered.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        dir_row_t           row;
        xfer_t              x;
        logic               hit;
        iq_t                res;
        iq_t                typed_iq;
        logic [PDATA_W-1:0] rd;
        int                 burst_left;
        int                 gap;
        int                 phase_factors [N_PHASES];

        // Known values on every input from time zero, with reset held low.
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_COEF;
        in_ch.coef_index <= '0;
        in_ch.coef_value <= '0;
        in_ch.sample_i   <= '0;
        in_ch.sample_q   <= '0;

        for (int k = 0; k < NUM_TAPS; k++)
        begin
            hist_i[k]    = '0;
            hist_q[k]    = '0;
            tap_store[k] = '0;
        end
        wr_ptr     = 0;
        phase_cnt  = 0;
        factor_reg = FACTOR_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register must come out of reset at its documented value.
        apb_xfer(1'b0, '0, rd);
        if (rd !== PDATA_W'(FACTOR_RESET))
            report($sformatf("factor after reset %0d, want %0d", rd, FACTOR_RESET));

        // Write every tap before the first pass: tap 0 at -1.0, the rest zero.
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            x            = random_xfer(100);
            x.coef_index = COEF_IDX_W'(k);
            x.coef_value = (k == 0) ? DATA_W'(-32768) : '0;
            send(x, hit, res);
        end

        // Directed table.
        for (int r = 0; r < N_DIR; r++)
        begin
            row = DIR_ROWS[r];
            if (row.factor != NO_CFG)
            begin
                drain();
                set_factor(row.factor);
            end
            x.mode       = row.mode;
            x.coef_index = COEF_IDX_W'(row.idx);
            x.coef_value = DATA_W'(row.cval);
            x.sample_i   = DATA_W'(row.si);
            x.sample_q   = DATA_W'(row.sq);
            send(x, hit, res);
            if (row.typed)
            begin
                typed_iq.out_i = DATA_W'(row.ei);
                typed_iq.out_q = DATA_W'(row.eq);
                owe_result(typed_iq);
            end
            else if (hit)
            begin
                owe_result(res);
            end
        end

        // Reload the whole tap store with random values before the random phases.
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            x            = random_xfer(100);
            x.coef_index = COEF_IDX_W'(k);
            send(x, hit, res);
        end

        // Random phases, each under its own factor: reset value, zero, both ends, values
        // past the maximum, a few ordinary ones and a random one. Each factor write follows
        // a full drain, which also gives the output side time to empty with intake paused.
        phase_factors = '{int'(FACTOR_RESET), 1, 0, FACTOR_MAX, FACTOR_TOP,
                          FACTOR_MAX + 1, 3, 16, 2, 0};
        phase_factors[N_PHASES - 1] = $urandom_range(1, FACTOR_TOP);
        burst_left = 0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            set_factor(phase_factors[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    // Mostly short bursts, now and then a long unbroken one.
                    burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12);
                    gap = $urandom_range(0, 12);
                    if (gap > 0)
                    begin
                        in_ch.valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                send(random_xfer(COEF_PCT), hit, res);
                if (hit)
                    owe_result(res);
                burst_left--;
            end
        end

        drain();

        $display("Covered %0d tap loads and %0d samples; %0d filtered outputs checked,",
                 n_taps, n_samples, n_checked);
        $display("%0d rail hits; factor written %0d times (0, 1, %0d, above it, mid-count drop).",
                 n_sat, n_cfg, FACTOR_MAX);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
rtl/core/cfd_pkg.sv
rtl/core/cfd_in_if.sv
rtl/core/cfd_out_if.sv
rtl/core/cfd_ram.sv
rtl/core/cfd_datapath.sv
rtl/core/cfd_ctrl.sv
rtl/core/complex_fir_decimator.sv
test/testbench.sv
